/* hdl/clock_page_replacement_top_defines.svh */
// Assertion macros shared by the clock page replacement RTL.
`ifndef CLOCK_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CLKPR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CLKPR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/clkpr_pkg.sv */
// Shared types and constants of the clock page replacement block.
`default_nettype none
package clkpr_pkg;

	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
	localparam int CNT_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SWEEP,
		ST_FILL,
		ST_DONE
	} state_t;

	// frame store controls; all updates use the write address
	typedef struct packed {
		logic rd_en;
		logic mem_wr;
		logic ref_set;
		logic ref_clr;
	} store_ctl_t;

	// completion of one access
	typedef struct packed {
		logic fire;
		logic hit;
		logic ev_valid;
	} done_t;

endpackage
`default_nettype wire

/* hdl/clkpr_ifs.sv */
// Handshake interfaces of the clock page replacement block.
`default_nettype none
interface clkpr_req_if #(parameter int PAGE_BITS = 16);
	logic valid;
	logic ready;
	logic [PAGE_BITS-1:0] page;
	modport source(output valid, output page, input ready);
	modport sink(input valid, input page, output ready);
endinterface

interface clkpr_rsp_if #(parameter int PAGE_BITS = 16, parameter int IDX_BITS = 4);
	logic valid;
	logic ready;
	logic hit;
	logic [IDX_BITS-1:0] frame_index;
	logic evicted_valid;
	logic [PAGE_BITS-1:0] evicted_page;
	logic [clkpr_pkg::CNT_W-1:0] access_count;
	logic [clkpr_pkg::CNT_W-1:0] hit_count;
	logic [clkpr_pkg::CNT_W-1:0] miss_count;
	modport source(output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output access_count, output hit_count, output miss_count,
		input ready);
	modport sink(input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input access_count, input hit_count, input miss_count,
		output ready);
endinterface

interface clkpr_cfg_if;
	logic valid;
	logic ready;
	logic [clkpr_pkg::CFG_W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/clkpr_frame_store.sv */
// Frame store: page memory with registered read, valid and reference bits.
`default_nettype none
module clkpr_frame_store #(
	parameter int FRAMES = 16,
	parameter int PAGE_BITS = 16,
	parameter int IW = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire clkpr_pkg::store_ctl_t ctl,
	input  wire logic [IW-1:0]         rd_addr,
	input  wire logic [IW-1:0]         wr_addr,
	input  wire logic [PAGE_BITS-1:0]  wr_data,
	output logic      [PAGE_BITS-1:0]  rd_data,
	output logic      [FRAMES-1:0]     valid_vec,
	output logic      [FRAMES-1:0]     ref_vec
);

	logic [PAGE_BITS-1:0] mem [FRAMES];
	logic [PAGE_BITS-1:0] rd_data_q;
	logic [FRAMES-1:0]    valid_q;
	logic [FRAMES-1:0]    ref_q;

	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ref_q   <= '0;
		end else begin
			if (ctl.mem_wr) begin
				valid_q[wr_addr] <= 1'b1;
				ref_q[wr_addr]   <= 1'b1;
			end else if (ctl.ref_set) begin
				ref_q[wr_addr] <= 1'b1;
			end else if (ctl.ref_clr) begin
				ref_q[wr_addr] <= 1'b0;
			end
		end
	end

	assign rd_data   = rd_data_q;
	assign valid_vec = valid_q;
	assign ref_vec   = ref_q;

endmodule
`default_nettype wire

/* hdl/clkpr_seq.sv */
// Sequencer: frame search with the shared page comparator, then on a miss the clock sweep.
`default_nettype none
module clkpr_seq #(
	parameter int FRAMES = 16,
	parameter int PAGE_BITS = 16,
	parameter int IW = 4,
	parameter int NW = 5
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [PAGE_BITS-1:0]        start_page,
	input  wire logic [clkpr_pkg::CFG_W-1:0] num_frames,
	output logic                             idle,
	input  wire logic                        out_free,
	output clkpr_pkg::store_ctl_t            ctl,
	output logic      [IW-1:0]               rd_addr,
	output logic      [IW-1:0]               wr_addr,
	output logic      [PAGE_BITS-1:0]        wr_data,
	input  wire logic [PAGE_BITS-1:0]        rd_data,
	input  wire logic [FRAMES-1:0]           valid_vec,
	input  wire logic [FRAMES-1:0]           ref_vec,
	output clkpr_pkg::done_t                 done,
	output logic      [IW-1:0]               slot,
	output logic      [PAGE_BITS-1:0]        ev_page
);

	clkpr_pkg::state_t state_q, state_d;

	logic [PAGE_BITS-1:0] page_q;
	logic [NW-1:0]        n_q;
	logic [NW-1:0]        rd_idx_q;
	logic                 cmp_pend_q;
	logic [IW-1:0]        cmp_idx_q;
	logic [IW-1:0]        hand_q;
	logic [IW-1:0]        slot_q;
	logic                 hit_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;

	logic [NW-1:0] n_next;
	logic          issue;
	logic          match;
	logic          last_cmp;
	logic          victim;
	logic [IW-1:0] hand_inc;
	logic [IW-1:0] slot_inc;
	logic [IW-1:0] hand_start;

	// frames in use: zero counts as one, clamp at the array size
	always_comb begin
		if (num_frames == '0) begin
			n_next = NW'(1);
		end else if (int'(num_frames) > FRAMES) begin
			n_next = NW'(FRAMES);
		end else begin
			n_next = NW'(num_frames);
		end
	end

	// shared comparator sees the page read in the previous cycle
	assign match    = cmp_pend_q && valid_vec[cmp_idx_q] && (rd_data == page_q);
	assign last_cmp = cmp_pend_q && (NW'(cmp_idx_q) == n_q - NW'(1));
	assign issue    = (state_q == clkpr_pkg::ST_SEARCH) && (rd_idx_q < n_q) && !match;
	assign victim   = !valid_vec[hand_q] || !ref_vec[hand_q];

	assign hand_inc   = (NW'(hand_q) + NW'(1) >= n_q) ? '0 : hand_q + IW'(1);
	assign slot_inc   = (NW'(slot_q) + NW'(1) >= n_q) ? '0 : slot_q + IW'(1);
	assign hand_start = (NW'(hand_q) >= n_q) ? '0 : hand_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clkpr_pkg::ST_IDLE: begin
				if (start) begin
					state_d = clkpr_pkg::ST_SEARCH;
				end
			end
			clkpr_pkg::ST_SEARCH: begin
				if (match) begin
					state_d = clkpr_pkg::ST_DONE;
				end else if (last_cmp) begin
					state_d = clkpr_pkg::ST_SWEEP;
				end
			end
			clkpr_pkg::ST_SWEEP: begin
				if (victim) begin
					state_d = clkpr_pkg::ST_FILL;
				end
			end
			clkpr_pkg::ST_FILL: begin
				state_d = clkpr_pkg::ST_DONE;
			end
			clkpr_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = clkpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = clkpr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl     = '0;
		rd_addr = hand_q;
		wr_addr = hand_q;
		unique case (state_q)
			clkpr_pkg::ST_SEARCH: begin
				ctl.rd_en   = issue;
				ctl.ref_set = match;
				rd_addr     = rd_idx_q[IW-1:0];
				wr_addr     = cmp_idx_q;
			end
			clkpr_pkg::ST_SWEEP: begin
				// victim: fetch old page; otherwise take the second chance away
				ctl.rd_en   = victim;
				ctl.ref_clr = !victim;
			end
			clkpr_pkg::ST_FILL: begin
				ctl.mem_wr = 1'b1;
				wr_addr    = slot_q;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= clkpr_pkg::ST_IDLE;
			hand_q     <= '0;
			cmp_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				clkpr_pkg::ST_IDLE: begin
					cmp_pend_q <= 1'b0;
				end
				clkpr_pkg::ST_SEARCH: begin
					cmp_pend_q <= issue;
					if (!match && last_cmp) begin
						hand_q <= hand_start;
					end
				end
				clkpr_pkg::ST_SWEEP: begin
					cmp_pend_q <= 1'b0;
					if (!victim) begin
						hand_q <= hand_inc;
					end
				end
				clkpr_pkg::ST_FILL: begin
					hand_q <= slot_inc;
				end
				default: begin
					cmp_pend_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			clkpr_pkg::ST_IDLE: begin
				if (start) begin
					page_q     <= start_page;
					n_q        <= n_next;
					rd_idx_q   <= '0;
					hit_q      <= 1'b0;
					ev_valid_q <= 1'b0;
					ev_page_q  <= '0;
				end
			end
			clkpr_pkg::ST_SEARCH: begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + NW'(1);
				end
				cmp_idx_q <= rd_idx_q[IW-1:0];
				if (match) begin
					hit_q  <= 1'b1;
					slot_q <= cmp_idx_q;
				end
			end
			clkpr_pkg::ST_SWEEP: begin
				if (victim) begin
					slot_q <= hand_q;
				end
			end
			clkpr_pkg::ST_FILL: begin
				ev_valid_q <= valid_vec[slot_q];
				ev_page_q  <= valid_vec[slot_q] ? rd_data : '0;
			end
			default: begin
				hit_q <= hit_q;
			end
		endcase
	end

	assign idle          = (state_q == clkpr_pkg::ST_IDLE);
	assign wr_data       = page_q;
	assign done.fire     = (state_q == clkpr_pkg::ST_DONE) && out_free;
	assign done.hit      = hit_q;
	assign done.ev_valid = ev_valid_q;
	assign slot          = slot_q;
	assign ev_page       = ev_page_q;

endmodule
`default_nettype wire

/* hdl/clock_page_replacement_top.sv */
// Top level of the clock (second chance) page replacement block.
//
//   channel   modport   beat carries
//   -------   -------   ------------------------------------------------------
//   req       sink      page
//   rsp       source    hit, frame_index, evicted_valid, evicted_page, counters
//   cfg       sink      data = num_frames (always ready)
//
// Sequence: one access at a time. A hit in frame k ends the search there
// and goes on to the done step; a miss searches all n frames in use, sweeps
// the hand past s frames (s <= n) to a victim, then takes one fill and one
// done step. The done step loads the result register. The search reads one
// frame at a time through the memory read port; the sweep steps the hand.
// Reset clears valid and reference bits, the hand and the counters; the page
// memory holds garbage until each frame is filled.
// A result waiting on rsp does not block req; the done step stalls only if
// the previous result is still unclaimed.
`default_nettype none
`include "clock_page_replacement_top_defines.svh"
module clock_page_replacement_top #(
	parameter int FRAMES = 16,
	parameter int PAGE_BITS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	clkpr_req_if.sink req,
	clkpr_rsp_if.source rsp,
	clkpr_cfg_if.sink cfg
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int NW = $clog2(FRAMES + 1);

	// configuration register
	logic [clkpr_pkg::CFG_W-1:0] num_frames_q;

	// sequencer <-> frame store
	clkpr_pkg::store_ctl_t ctl;
	logic [IW-1:0]         rd_addr;
	logic [IW-1:0]         wr_addr;
	logic [PAGE_BITS-1:0]  wr_data;
	logic [PAGE_BITS-1:0]  rd_data;
	logic [FRAMES-1:0]     valid_vec;
	logic [FRAMES-1:0]     ref_vec;

	clkpr_pkg::done_t      done;
	logic [IW-1:0]         slot;
	logic [PAGE_BITS-1:0]  ev_page;
	logic                  seq_idle;
	logic                  out_free;

	// result register and running counters
	logic                        rsp_valid_q;
	logic                        hit_q;
	logic [IW-1:0]               frame_index_q;
	logic                        ev_valid_q;
	logic [PAGE_BITS-1:0]        ev_page_q;
	logic [clkpr_pkg::CNT_W-1:0] acc_cnt_q;
	logic [clkpr_pkg::CNT_W-1:0] hit_cnt_q;
	logic [clkpr_pkg::CNT_W-1:0] miss_cnt_q;

	// the user must make register writes arrive only while idle (unenforced by the block); the port never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q <= clkpr_pkg::CFG_RESET;
		end else if (cfg.valid) begin
			num_frames_q <= cfg.data;
		end
	end

	assign req.ready = seq_idle;
	assign out_free  = !rsp_valid_q || rsp.ready;

	clkpr_seq #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.IW        (IW),
		.NW        (NW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (req.valid && seq_idle),
		.start_page (req.page),
		.num_frames (num_frames_q),
		.idle       (seq_idle),
		.out_free   (out_free),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_data    (rd_data),
		.valid_vec  (valid_vec),
		.ref_vec    (ref_vec),
		.done       (done),
		.slot       (slot),
		.ev_page    (ev_page)
	);

	clkpr_frame_store #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.IW        (IW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_data   (rd_data),
		.valid_vec (valid_vec),
		.ref_vec   (ref_vec)
	);

	// valid flag and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			acc_cnt_q   <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
		end else if (done.fire) begin
			rsp_valid_q <= 1'b1;
			acc_cnt_q   <= acc_cnt_q + clkpr_pkg::CNT_W'(1);
			if (done.hit) begin
				hit_cnt_q <= hit_cnt_q + clkpr_pkg::CNT_W'(1);
			end else begin
				miss_cnt_q <= miss_cnt_q + clkpr_pkg::CNT_W'(1);
			end
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (done.fire) begin
			hit_q         <= done.hit;
			frame_index_q <= slot;
			ev_valid_q    <= done.ev_valid;
			ev_page_q     <= ev_page;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = hit_q;
	assign rsp.frame_index   = frame_index_q;
	assign rsp.evicted_valid = ev_valid_q;
	assign rsp.evicted_page  = ev_page_q;
	assign rsp.access_count  = acc_cnt_q;
	assign rsp.hit_count     = hit_cnt_q;
	assign rsp.miss_count    = miss_cnt_q;

	// every access is either a hit or a miss, modulo the counter width
	`CLKPR_ASSERT_IMP(a_cnt_sum, clk, arst_n, rsp.valid, rsp.access_count == rsp.hit_count + rsp.miss_count, "access count differs from hits plus misses")
	// a hit never replaces a page
	`CLKPR_ASSERT_IMP(a_hit_no_evict, clk, arst_n, rsp.valid && rsp.hit, !rsp.evicted_valid, "hit reported with an eviction")
	// the sequencer is busy right after taking a beat
	`CLKPR_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready, "request taken while an access is in flight")

endmodule
`default_nettype wire

/* bench/clock_page_replacement_top_test.sv */
// Self-checking testbench for the clock page replacement block: random handshakes, scoreboard.
module clock_page_replacement_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAMES = 16;
	localparam int PAGE_BITS = 16;
	// worst miss: full search, full sweep, fill, done; plus margin
	localparam int DRAIN_CYCLES = 4 * FRAMES + 8;
	localparam int CYCLE_LIMIT = 400000;
	// accepted accesses before the receiver goes quiet for a long stretch
	localparam int STALL_AT = 520;
	localparam int STALL_CYCLES = 300;

	// one expected result beat
	typedef struct packed {
		logic hit;
		logic [3:0] frame_index;
		logic evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [clkpr_pkg::CNT_W-1:0] access_count;
		logic [clkpr_pkg::CNT_W-1:0] hit_count;
		logic [clkpr_pkg::CNT_W-1:0] miss_count;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n;

	clkpr_req_if #(.PAGE_BITS(PAGE_BITS)) req_if ();
	clkpr_rsp_if #(.PAGE_BITS(PAGE_BITS), .IDX_BITS(4)) rsp_if ();
	clkpr_cfg_if cfg_if ();

	clock_page_replacement_top #(
		.FRAMES(FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Shadow copy of the frame table, hand, counters and register.
	// Owned by the driver process only.
	// ---------------------------------------------------------------
	logic [PAGE_BITS-1:0] shadow_pages [FRAMES];
	bit shadow_valid [FRAMES];
	bit shadow_ref [FRAMES];
	int unsigned shadow_hand;
	logic [clkpr_pkg::CNT_W-1:0] shadow_accesses;
	logic [clkpr_pkg::CNT_W-1:0] shadow_hits;
	logic [clkpr_pkg::CNT_W-1:0] shadow_misses;
	logic [clkpr_pkg::CFG_W-1:0] shadow_frames_reg;

	access_result_t expected_results [$];
	logic [PAGE_BITS-1:0] pending_pages [$];

	int errors = 0;
	int accepted_pages = 0;
	int send_gap_pct = 35;
	int recv_gap_pct = 46;
	logic rsp_stall = 1'b0;
	int cycle_count = 0;

	// One access against the shadow table: search, then second-chance sweep on a miss.
	function automatic access_result_t access_page(input logic [PAGE_BITS-1:0] pg);
		access_result_t r;
		int unsigned n;
		int unsigned slot;
		bit found;
		bit placed;
		n = shadow_frames_reg;
		// zero frames means one; anything past the table means the whole table
		if (n < 1) n = 1;
		if (n > FRAMES) n = FRAMES;
		r = '0;
		slot = 0;
		found = 1'b0;
		placed = 1'b0;
		shadow_accesses = shadow_accesses + 1'b1;
		// lowest numbered resident copy wins when a page sits in two frames
		for (int i = 0; i < n; i++) begin
			if (!found && shadow_valid[i] && shadow_pages[i] == pg) begin
				slot = i;
				found = 1'b1;
			end
		end
		if (found) begin
			shadow_hits = shadow_hits + 1'b1;
			shadow_ref[slot] = 1'b1;
		end else begin
			// hand left past n by a lowered frame count restarts at frame 0
			if (shadow_hand >= n) shadow_hand = 0;
			for (int s = 0; s <= 2 * n; s++) begin
				if (!placed) begin
					if (!shadow_valid[shadow_hand] || !shadow_ref[shadow_hand]) begin
						slot = shadow_hand;
						placed = 1'b1;
					end else begin
						shadow_ref[shadow_hand] = 1'b0;
						shadow_hand = (shadow_hand + 1 >= n) ? 0 : shadow_hand + 1;
					end
				end
			end
			if (shadow_valid[slot]) begin
				r.evicted_valid = 1'b1;
				r.evicted_page = shadow_pages[slot];
			end
			shadow_pages[slot] = pg;
			shadow_valid[slot] = 1'b1;
			shadow_ref[slot] = 1'b1;
			shadow_hand = (slot + 1 >= n) ? 0 : slot + 1;
			shadow_misses = shadow_misses + 1'b1;
		end
		r.hit = found;
		r.frame_index = slot[3:0];
		r.access_count = shadow_accesses;
		r.hit_count = shadow_hits;
		r.miss_count = shadow_misses;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Driver: offers pending pages on req, keeps valid up until the beat
	// is taken, and runs the shadow table on every accepted beat. Config
	// beats are folded into the shadow register here too.
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.page <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				shadow_pages[i] = '0;
				shadow_valid[i] = 1'b0;
				shadow_ref[i] = 1'b0;
			end
			shadow_hand = 0;
			shadow_accesses = '0;
			shadow_hits = '0;
			shadow_misses = '0;
			shadow_frames_reg = clkpr_pkg::CFG_RESET;
		end else begin
			if (cfg_if.valid && cfg_if.ready)
				shadow_frames_reg = cfg_if.data;
			if (req_if.valid && req_if.ready) begin
				expected_results.push_back(access_page(req_if.page));
				accepted_pages++;
			end
			// new beat only once the current one is gone
			if (!req_if.valid || req_if.ready) begin
				if (pending_pages.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					req_if.valid <= 1'b1;
					req_if.page <= pending_pages.pop_front();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [clkpr_pkg::CNT_W-1:0] want,
		input logic [clkpr_pkg::CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// ---------------------------------------------------------------
	// Monitor: random backpressure on rsp, each accepted beat checked
	// against the oldest expectation.
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : monitor
		access_result_t want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no access outstanding");
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("hit", want.hit, rsp_if.hit);
					check_field("frame_index", want.frame_index, rsp_if.frame_index);
					check_field("evicted_valid", want.evicted_valid, rsp_if.evicted_valid);
					check_field("evicted_page", want.evicted_page, rsp_if.evicted_page);
					check_field("access_count", want.access_count, rsp_if.access_count);
					check_field("hit_count", want.hit_count, rsp_if.hit_count);
					check_field("miss_count", want.miss_count, rsp_if.miss_count);
				end
			end
			rsp_if.ready <= !rsp_stall && ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Long receiver hold-off partway into the last phase; the block fills
	// and must push back on req while the sender keeps offering.
	initial begin
		wait (accepted_pages >= STALL_AT);
		@(posedge clk);
		rsp_stall <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		rsp_stall <= 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Sender stops until every result is back, then the block gets time to go idle.
	task automatic settle();
		while (pending_pages.size() != 0 || expected_results.size() != 0 || req_if.valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// num_frames write, only from an idle block
	task automatic write_frames(input logic [clkpr_pkg::CFG_W-1:0] value);
		settle();
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic queue_pages(input logic [PAGE_BITS-1:0] list [$]);
		@(negedge clk);
		foreach (list[i]) pending_pages.push_back(list[i]);
	endtask

	// Working set a bit larger than n for a hit/miss mix, plus full-range noise.
	task automatic queue_random(input int count, input int n);
		logic [PAGE_BITS-1:0] pg;
		@(negedge clk);
		repeat (count) begin
			case ($urandom_range(9))
				0, 1: pg = PAGE_BITS'($urandom_range(16'hFFFF));
				2, 3: pg = PAGE_BITS'(16'hFF00 + $urandom_range(n + 2));
				default: pg = PAGE_BITS'(16'h0040 + $urandom_range(n + n / 2 + 1));
			endcase
			pending_pages.push_back(pg);
		end
	endtask

	task automatic set_gaps(input int send_pct, input int recv_pct);
		@(negedge clk);
		send_gap_pct = send_pct;
		recv_gap_pct = recv_pct;
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.page = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame count: field extremes, then hits on two of them
		queue_pages('{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0000, 16'hAAAA});
		// two frames, hand sits past them: restart at 0, full sweep clears both bits
		write_frames(5'd2);
		queue_pages('{16'h1234, 16'h5555, 16'h1234});
		// back to 16: 5555 now in frames 1 and 2 (lowest wins), AAAA kept in frame 3
		write_frames(5'd16);
		queue_pages('{16'h5555, 16'hAAAA});
		// zero means one frame: hit, then sweep wraps onto the same frame
		write_frames(5'd0);
		queue_pages('{16'h7777, 16'h7777, 16'h8888});
		// all register bits set, clamps to the full table
		write_frames(5'd31);
		queue_pages('{16'h0001, 16'h0002});

		write_frames(5'd4);
		queue_random(120, 4);
		write_frames(5'd16);
		queue_random(120, 16);

		write_frames(5'd1);
		set_gaps(46, 35);
		queue_random(100, 1);
		write_frames(5'd9);
		queue_random(120, 9);

		// past the table size; no idling here, long receiver stall lands in this phase
		write_frames(5'd20);
		set_gaps(0, 0);
		queue_random(240, 16);

		settle();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/clkpr_pkg.sv
hdl/clkpr_ifs.sv
hdl/clkpr_frame_store.sv
hdl/clkpr_seq.sv
hdl/clock_page_replacement_top.sv
bench/clock_page_replacement_top_test.sv
